/* hw/rtl/cartridge_header_decoder_unit_assert.svh */
// assertion macros for the rtl, included by chd_back
`ifndef CARTRIDGE_HEADER_DECODER_UNIT_ASSERT_SVH
`define CARTRIDGE_HEADER_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define CHD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("chd assertion failed");

// next-cycle implication
`define CHD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("chd assertion failed");

`endif

/* hw/rtl/chd_pkg.sv */
package chd_pkg;

  localparam logic [8:0] TITLE_FIRST = 9'h134;
  localparam logic [8:0] TITLE_LAST  = 9'h143;
  localparam logic [8:0] FOURTH_POS  = 9'h137;
  localparam logic [8:0] COLOUR_POS  = 9'h143;
  localparam logic [8:0] SUPER_POS   = 9'h146;
  localparam logic [8:0] TYPE_POS    = 9'h147;
  localparam logic [8:0] ROMSZ_POS   = 9'h148;
  localparam logic [8:0] RAMSZ_POS   = 9'h149;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam int unsigned SUM_KEY_CNT = 79;
  localparam int unsigned LETTER_CNT  = 29;
  localparam int unsigned PAL_CNT     = 94;
  localparam logic [6:0]  SPLIT_FROM  = 7'h41;
  localparam logic [6:0]  SPLIT_STEP  = 7'd14;

  localparam logic [1:0] MACH_MONO   = 2'd0;
  localparam logic [1:0] MACH_COLOUR = 2'd1;
  localparam logic [1:0] MACH_SUPER  = 2'd2;

  localparam logic [3:0] CTRL_NONE  = 4'd0;
  localparam logic [3:0] CTRL_MBC1  = 4'd1;
  localparam logic [3:0] CTRL_MBC2  = 4'd2;
  localparam logic [3:0] CTRL_MBC3  = 4'd3;
  localparam logic [3:0] CTRL_MBC5  = 4'd4;
  localparam logic [3:0] CTRL_MBC6  = 4'd5;
  localparam logic [3:0] CTRL_MBC7  = 4'd6;
  localparam logic [3:0] CTRL_HUC1  = 4'd7;
  localparam logic [3:0] CTRL_HUC3  = 4'd8;
  localparam logic [3:0] CTRL_MMM01 = 4'd9;

  localparam logic [7:0] COLOUR_ONLY  = 8'hC0;
  localparam logic [7:0] COLOUR_DUAL  = 8'h80;
  localparam logic [7:0] SUPER_ON     = 8'h03;
  localparam logic [7:0] ROM_CODE_MAX = 8'd8;
  localparam logic [7:0] ROM_ALT_LO   = 8'h52;
  localparam logic [7:0] ROM_ALT_HI   = 8'h54;
  localparam logic [7:0] ROM_ALT_BANKS_CODE = 8'd6;
  localparam logic [7:0] RAM_CODE_CNT = 8'd6;

  typedef struct packed {
    logic [7:0] title_sum;
    logic [7:0] fourth_char;
    logic [7:0] colour_flag;
    logic [7:0] super_flag;
    logic [7:0] type_code;
    logic [7:0] rom_code;
    logic [7:0] ram_code;
  } hdr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [7:0] SUM_KEYS [SUM_KEY_CNT] = '{
    8'h00, 8'h88, 8'h16, 8'h36, 8'hD1, 8'hDB, 8'hF2, 8'h3C, 8'h8C, 8'h92, 8'h3D, 8'h5C,
    8'h58, 8'hC9, 8'h3E, 8'h70, 8'h1D, 8'h59, 8'h69, 8'h19, 8'h35, 8'hA8, 8'h14, 8'hAA,
    8'h75, 8'h95, 8'h99, 8'h34, 8'h6F, 8'h15, 8'hFF, 8'h97, 8'h4B, 8'h90, 8'h17, 8'h10,
    8'h39, 8'hF7, 8'hF6, 8'hA2, 8'h49, 8'h4E, 8'h43, 8'h68, 8'hE0, 8'h8B, 8'hF0, 8'hCE,
    8'h0C, 8'h29, 8'hE8, 8'hB7, 8'h86, 8'h9A, 8'h52, 8'h01, 8'h9D, 8'h71, 8'h9C, 8'hBD,
    8'h5D, 8'h6D, 8'h67, 8'h3F, 8'h6B, 8'hB3, 8'h46, 8'h28, 8'hA5, 8'hC6, 8'hD3, 8'h27,
    8'h61, 8'h18, 8'h66, 8'h6A, 8'hBF, 8'h0D, 8'hF4
  };

  localparam logic [7:0] FOURTH_LETTERS [LETTER_CNT] = '{
    8'h42, 8'h45, 8'h46, 8'h41, 8'h41, 8'h52, 8'h42, 8'h45,
    8'h4B, 8'h45, 8'h4B, 8'h20, 8'h52, 8'h2D, 8'h55, 8'h52,
    8'h41, 8'h52, 8'h20, 8'h49, 8'h4E, 8'h41, 8'h49, 8'h4C,
    8'h49, 8'h43, 8'h45, 8'h20, 8'h52
  };

  localparam logic [7:0] PALETTE_CODES [PAL_CNT] = '{
    8'h7C, 8'h08, 8'h12, 8'hA3, 8'hA2, 8'h07, 8'h87, 8'h4B, 8'h20, 8'h12, 8'h65, 8'hA8,
    8'h16, 8'hA9, 8'h86, 8'hB1, 8'h68, 8'hA0, 8'h87, 8'h66, 8'h12, 8'hA1, 8'h30, 8'h3C,
    8'h12, 8'h85, 8'h12, 8'h64, 8'h1B, 8'h07, 8'h06, 8'h6F, 8'h6E, 8'h6E, 8'hAE, 8'hAF,
    8'h6F, 8'hB2, 8'hAF, 8'hB2, 8'hA8, 8'hAB, 8'h6F, 8'hAF, 8'h86, 8'hAE, 8'hA2, 8'hA2,
    8'h12, 8'hAF, 8'h13, 8'h12, 8'hA1, 8'h6E, 8'hAF, 8'hAF, 8'hAD, 8'h06, 8'h4C, 8'h6E,
    8'hAF, 8'hAF, 8'h12, 8'h7C, 8'hAC, 8'hA8, 8'h6A, 8'h6E, 8'h13, 8'hA0, 8'h2D, 8'hA8,
    8'h2B, 8'hAC, 8'h64, 8'hAC, 8'h6D, 8'h87, 8'hBC, 8'h60, 8'hB4, 8'h13, 8'h72, 8'h7C,
    8'hB5, 8'hAE, 8'hAE, 8'h7C, 8'h7C, 8'h65, 8'hA2, 8'h6C, 8'h64, 8'h85
  };

  localparam logic [4:0] RAM_BANKS [6] = '{5'd1, 5'd1, 5'd1, 5'd4, 5'd16, 5'd8};

  typedef logic [6:0] sum_idx_tab_t [256];

  // first matching key index for every sum, 0 when absent
  function automatic sum_idx_tab_t build_sum_idx();
    sum_idx_tab_t tab;
    for (int s = 0; s < 256; s++) begin
      tab[s] = 7'd0;
    end
    for (int k = SUM_KEY_CNT - 1; k >= 0; k--) begin
      tab[SUM_KEYS[k]] = 7'(k);
    end
    return tab;
  endfunction

  localparam sum_idx_tab_t SUM_IDX = build_sum_idx();

endpackage

/* hw/rtl/cartridge_header_decoder_unit.sv */
// the last byte pushes a header into the two-entry queue, which lets bytes of the next
// header flow while a result waits; ST_IDLE pops one header at a time, ST_LOOK
// registers its result, ST_OUT offers it; one byte per cycle while the queue has room
// reset: rst_ni low clears the captured header, the queue and the output valid
module cartridge_header_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // offset[8:0], header_byte[16:9], zero pad
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[0], machine_kind[2:1], controller_kind[6:3], rom_banks[16:7],
  // ram_banks[21:17], ram_code_bad[22], battery[23], clock_chip[24], rumble[25],
  // tilt_sensor[26], palette_info[34:27], zero pad
  output logic [39:0] m_axis_tdata_o
);

  logic             accept;
  logic             push;
  chd_pkg::hdr_t    push_data;
  chd_pkg::hdr_t    pop_data;
  logic             pop;
  chd_pkg::q_stat_t q_stat;

  logic       status;
  logic [1:0] machine_kind;
  logic [3:0] controller_kind;
  logic [9:0] rom_banks;
  logic [4:0] ram_banks;
  logic       ram_code_bad, battery, clock_chip, rumble, tilt_sensor;
  logic [7:0] palette_info;

  assign s_axis_tready_o = !q_stat.full;
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  chd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .offset_i      (s_axis_tdata_i[8:0]),
    .header_byte_i (s_axis_tdata_i[16:9]),
    .last_i        (s_axis_tlast_i),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  chd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  chd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .stat_i            (q_stat),
    .data_i            (pop_data),
    .pop_o             (pop),
    .m_tvalid_o        (m_axis_tvalid_o),
    .m_tready_i        (m_axis_tready_i),
    .status_o          (status),
    .machine_kind_o    (machine_kind),
    .controller_kind_o (controller_kind),
    .rom_banks_o       (rom_banks),
    .ram_banks_o       (ram_banks),
    .ram_code_bad_o    (ram_code_bad),
    .battery_o         (battery),
    .clock_chip_o      (clock_chip),
    .rumble_o          (rumble),
    .tilt_sensor_o     (tilt_sensor),
    .palette_info_o    (palette_info)
  );

  assign m_axis_tdata_o = {5'd0, palette_info, tilt_sensor, rumble, clock_chip, battery,
                           ram_code_bad, ram_banks, rom_banks, controller_kind,
                           machine_kind, status};

endmodule

/* hw/rtl/chd_front.sv */
module chd_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [8:0]   offset_i,
  input  logic [7:0]   header_byte_i,
  input  logic         last_i,
  output logic         push_o,
  output chd_pkg::hdr_t push_data_o
);

  chd_pkg::hdr_t hdr_q, hdr_d;

  always_comb begin
    hdr_d = hdr_q;
    if (offset_i >= chd_pkg::TITLE_FIRST && offset_i <= chd_pkg::TITLE_LAST) begin
      hdr_d.title_sum = hdr_q.title_sum + header_byte_i;
    end
    if (offset_i == chd_pkg::FOURTH_POS) hdr_d.fourth_char = header_byte_i;
    if (offset_i == chd_pkg::COLOUR_POS) hdr_d.colour_flag = header_byte_i;
    if (offset_i == chd_pkg::SUPER_POS)  hdr_d.super_flag  = header_byte_i;
    if (offset_i == chd_pkg::TYPE_POS)   hdr_d.type_code   = header_byte_i;
    if (offset_i == chd_pkg::ROMSZ_POS)  hdr_d.rom_code    = header_byte_i;
    if (offset_i == chd_pkg::RAMSZ_POS)  hdr_d.ram_code    = header_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        hdr_q <= '0;
      end else begin
        hdr_q <= hdr_d;
      end
    end
  end

  assign push_o      = accept_i & last_i;
  assign push_data_o = hdr_d;

endmodule

/* hw/rtl/chd_queue.sv */
module chd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  chd_pkg::hdr_t   push_data_i,
  input  logic            pop_i,
  output chd_pkg::hdr_t   pop_data_o,
  output chd_pkg::q_stat_t stat_o
);

  localparam logic [chd_pkg::QPTR_W:0] FULL_CNT = (chd_pkg::QPTR_W + 1)'(chd_pkg::QDEPTH);

  chd_pkg::hdr_t mem_q [chd_pkg::QDEPTH];
  logic [chd_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [chd_pkg::QPTR_W:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == FULL_CNT);
  assign stat_o.empty = (cnt_q == '0);

endmodule

/* hw/rtl/chd_back.sv */
`include "cartridge_header_decoder_unit_assert.svh"

module chd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  chd_pkg::q_stat_t stat_i,
  input  chd_pkg::hdr_t    data_i,
  output logic             pop_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic             status_o,
  output logic [1:0]       machine_kind_o,
  output logic [3:0]       controller_kind_o,
  output logic [9:0]       rom_banks_o,
  output logic [4:0]       ram_banks_o,
  output logic             ram_code_bad_o,
  output logic             battery_o,
  output logic             clock_chip_o,
  output logic             rumble_o,
  output logic             tilt_sensor_o,
  output logic [7:0]       palette_info_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  chd_pkg::hdr_t hdr_q;
  logic [6:0] idx_q;

  logic        status_d;
  logic [1:0]  machine_d;
  logic [3:0]  ctrl_d;
  logic [9:0]  rom_d;
  logic [4:0]  ram_d;
  logic        bad_d, batt_d, clk_d, rumble_d, tilt_d;
  logic [7:0]  pal_d;
  logic [4:0]  li;
  logic [6:0]  step;
  logic [6:0]  chosen;
  logic [7:0]  t;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: state_d = ST_OUT;
      ST_OUT: begin
        if (m_tready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // palette choice from the key index and the fourth title character
  always_comb begin
    li   = 5'(idx_q - chd_pkg::SPLIT_FROM);
    step = 7'd0;
    if (idx_q >= chd_pkg::SPLIT_FROM) begin
      if (chd_pkg::FOURTH_LETTERS[li] == hdr_q.fourth_char) begin
        step = 7'd0;
      end else if (chd_pkg::FOURTH_LETTERS[5'(li + 5'(chd_pkg::SPLIT_STEP))]
                   == hdr_q.fourth_char) begin
        step = chd_pkg::SPLIT_STEP;
      end else if (li == 5'd0 && chd_pkg::FOURTH_LETTERS[chd_pkg::LETTER_CNT - 1]
                   == hdr_q.fourth_char) begin
        step = 7'(2 * chd_pkg::SPLIT_STEP);
      end
    end
    chosen = idx_q + step;
    if (chosen >= 7'(chd_pkg::PAL_CNT)) chosen = 7'd0;
  end

  always_comb begin
    t         = hdr_q.type_code;
    status_d  = 1'b0;
    rom_d     = 10'd0;
    if (hdr_q.rom_code <= chd_pkg::ROM_CODE_MAX) begin
      rom_d = 10'd2 << hdr_q.rom_code[3:0];
    end else if (hdr_q.rom_code >= chd_pkg::ROM_ALT_LO &&
                 hdr_q.rom_code <= chd_pkg::ROM_ALT_HI) begin
      rom_d = 10'd2 << chd_pkg::ROM_ALT_BANKS_CODE[3:0];
    end else begin
      status_d = 1'b1;
    end

    if (hdr_q.ram_code < chd_pkg::RAM_CODE_CNT) begin
      ram_d = chd_pkg::RAM_BANKS[hdr_q.ram_code[2:0]];
      bad_d = 1'b0;
    end else begin
      ram_d = 5'd1;
      bad_d = 1'b1;
    end

    if (hdr_q.colour_flag == chd_pkg::COLOUR_DUAL ||
        hdr_q.colour_flag == chd_pkg::COLOUR_ONLY) begin
      machine_d = chd_pkg::MACH_COLOUR;
    end else if (hdr_q.super_flag == chd_pkg::SUPER_ON) begin
      machine_d = chd_pkg::MACH_SUPER;
    end else begin
      machine_d = chd_pkg::MACH_MONO;
    end

    case (t) inside
      [8'd1:8'd3]:   ctrl_d = chd_pkg::CTRL_MBC1;
      [8'd5:8'd6]:   ctrl_d = chd_pkg::CTRL_MBC2;
      [8'd11:8'd13]: ctrl_d = chd_pkg::CTRL_MMM01;
      [8'd15:8'd19]: ctrl_d = chd_pkg::CTRL_MBC3;
      [8'd25:8'd30]: ctrl_d = chd_pkg::CTRL_MBC5;
      8'd32:         ctrl_d = chd_pkg::CTRL_MBC6;
      8'd34:         ctrl_d = chd_pkg::CTRL_MBC7;
      8'd254:        ctrl_d = chd_pkg::CTRL_HUC3;
      8'd255:        ctrl_d = chd_pkg::CTRL_HUC1;
      default:       ctrl_d = chd_pkg::CTRL_NONE;
    endcase

    batt_d   = t inside {8'd3, 8'd6, 8'd9, 8'd13, 8'd15, 8'd16, 8'd19, 8'd27, 8'd30,
                         8'd255};
    clk_d    = t inside {8'd15, 8'd16};
    rumble_d = t inside {8'd28, 8'd29, 8'd30};
    tilt_d   = (t == 8'd34);
    pal_d    = (machine_d == chd_pkg::MACH_COLOUR) ? 8'd0 :
               chd_pkg::PALETTE_CODES[chosen];

    if (status_d) begin
      machine_d = chd_pkg::MACH_MONO;
      ctrl_d    = chd_pkg::CTRL_NONE;
      ram_d     = 5'd0;
      bad_d     = 1'b0;
      batt_d    = 1'b0;
      clk_d     = 1'b0;
      rumble_d  = 1'b0;
      tilt_d    = 1'b0;
      pal_d     = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      hdr_q <= data_i;
      idx_q <= chd_pkg::SUM_IDX[data_i.title_sum];
    end
    if (state_q == ST_LOOK) begin
      status_o          <= status_d;
      machine_kind_o    <= machine_d;
      controller_kind_o <= ctrl_d;
      rom_banks_o       <= rom_d;
      ram_banks_o       <= ram_d;
      ram_code_bad_o    <= bad_d;
      battery_o         <= batt_d;
      clock_chip_o      <= clk_d;
      rumble_o          <= rumble_d;
      tilt_sensor_o     <= tilt_d;
      palette_info_o    <= pal_d;
    end
  end

  assign m_tvalid_o = (state_q == ST_OUT);

  `CHD_ASSERT_NOW(a_pop_nonempty, pop_o, !stat_i.empty)
  `CHD_ASSERT_NEXT(a_look_then_out, state_q == ST_LOOK, m_tvalid_o)
  `CHD_ASSERT_NOW(a_err_zero, m_tvalid_o && status_o,
                  rom_banks_o == 10'd0 && ram_banks_o == 5'd0 && palette_info_o == 8'd0)
  `CHD_ASSERT_NOW(a_bad_one_bank, m_tvalid_o && ram_code_bad_o, ram_banks_o == 5'd1)

endmodule
